@@ rtl/autorange_capture_tachometer_core_macros.svh @@
// Assertion macros for the auto-ranging capture tachometer.
// Included by the core module, which checks its own sequencing; needs no package.
`ifndef AUTORANGE_CAPTURE_TACHOMETER_CORE_MACROS_SVH
`define AUTORANGE_CAPTURE_TACHOMETER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/act_pkg.sv @@
// Shared types and constants for the auto-ranging capture tachometer.
// Used by autorange_capture_tachometer_core and the testbench; depends on nothing else.
package act_pkg;

  // Timer ticks per microsecond (valid range 1 to 64).
  localparam int TICKS_PER_US = 16;
  localparam int TPU_SAFE     = (TICKS_PER_US > 0) ? TICKS_PER_US : 1;

  // Width of the shared divider; covers the speed numerator.
  localparam int DIV_W   = 25;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam int SPEED_NUM  = 30000000;
  localparam int US_PER_MS  = 1000;
  localparam int FINE_LIMIT = ((65535 / TPU_SAFE) * 2) / 3;
  localparam int MID_LIMIT  = ((8 * 65535 / TPU_SAFE) * 2) / 3;

  // Prescaler settings.
  typedef logic [6:0] prescale_t;
  localparam prescale_t PRESCALE_COARSE = 7'd64;
  localparam prescale_t PRESCALE_MID    = 7'd8;
  localparam prescale_t PRESCALE_FINE   = 7'd1;

  // Request codes.
  localparam logic [1:0] REQ_CAPTURE = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_STOP    = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] capture_count;
  } req_t;

  typedef struct packed {
    logic [24:0] speed;
    logic [31:0] elapsed_ms;
    logic        zero_interval;
  } rslt_t;

endpackage

@@ rtl/autorange_capture_tachometer_core.sv @@
// Auto-ranging capture tachometer: request sequencer, shared serial divider
// and result register. Depends on act_pkg and the assertion macro header.
//
// Start, stop and capture requests arrive as transactions on req. A measuring
// capture is accepted, then takes three passes of a single restoring
// divider that yields one quotient bit per cycle over 25 bits (count times
// prescaler over ticks per microsecond, half-turn time over 1000, and
// 30000000 over the half-turn time; the last is skipped for a zero time),
// then loads the result register. Start, stop, discarded captures and unused
// codes finish in the accepting cycle. The request side stalls while a
// capture is in the divider or while its result waits for a full result
// register; the result register itself holds one result until the receiver
// takes it. There is no clearing pass after reset.
`include "autorange_capture_tachometer_core_macros.svh"

module autorange_capture_tachometer_core
  import act_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  output logic  rslt_valid,
  input  logic  rslt_stall,
  output rslt_t rslt
);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_MS    = 3'd2;
  localparam logic [2:0] ST_SPEED = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;

  logic [2:0]        state;
  prescale_t         active_prescale;
  prescale_t         pending_prescale;
  logic [31:0]       elapsed_total;
  logic              first_pending;
  logic              stopped;
  logic [DIV_W-1:0]  half_us;
  logic [24:0]       speed;
  logic              zero_flag;

  // Shared divider registers: dividend shifts into the quotient.
  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;

  logic [DIV_W:0]    trial;
  logic              take;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  dvd_next;
  logic              div_last;
  logic [22:0]       product;
  logic              req_acc;

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;

  // Scaled tick count for the first division.
  assign product = 23'(req.capture_count) * 23'(active_prescale);

  // One restoring division step per cycle.
  always_comb begin
    trial    = {rem, dvd[DIV_W-1]};
    take     = (trial >= {1'b0, dsr});
    rem_next = take ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
    dvd_next = {dvd[DIV_W-2:0], take};
    div_last = (dcnt == DCNT_W'(DIV_W - 1));
  end

  // Sequencer, state update and divider control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      active_prescale  <= PRESCALE_COARSE;
      pending_prescale <= PRESCALE_COARSE;
      elapsed_total    <= '0;
      first_pending    <= 1'b1;
      stopped          <= 1'b1;
      rslt_valid       <= 1'b0;
      dcnt             <= '0;
    end else begin
      // A taken result is dropped here; the send state reloads it itself.
      if (rslt_valid && !rslt_stall && state != ST_SEND) begin
        rslt_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_acc) begin
            case (req.req_type)
              REQ_START: begin
                stopped <= 1'b0;
              end
              REQ_STOP: begin
                stopped          <= 1'b1;
                first_pending    <= 1'b1;
                elapsed_total    <= '0;
                active_prescale  <= PRESCALE_COARSE;
                pending_prescale <= PRESCALE_COARSE;
              end
              REQ_CAPTURE: begin
                active_prescale <= pending_prescale;
                if (first_pending || stopped) begin
                  first_pending <= 1'b0;
                end else begin
                  dvd   <= {2'b00, product};
                  dsr   <= DIV_W'(TPU_SAFE);
                  rem   <= '0;
                  dcnt  <= '0;
                  state <= ST_SCALE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCALE: begin
          if (div_last) begin
            half_us <= dvd_next;
            // Range the prescaler from the half-turn time.
            if (active_prescale > PRESCALE_FINE && dvd_next < DIV_W'(FINE_LIMIT)) begin
              pending_prescale <= PRESCALE_FINE;
            end else if (active_prescale > PRESCALE_MID &&
                         dvd_next < DIV_W'(MID_LIMIT)) begin
              pending_prescale <= PRESCALE_MID;
            end
            dvd   <= dvd_next;
            dsr   <= DIV_W'(US_PER_MS);
            rem   <= '0;
            dcnt  <= '0;
            state <= ST_MS;
          end else begin
            dvd  <= dvd_next;
            rem  <= rem_next;
            dcnt <= dcnt + DCNT_W'(1);
          end
        end
        ST_MS: begin
          if (div_last) begin
            elapsed_total <= elapsed_total + {{(32 - DIV_W){1'b0}}, dvd_next};
            rem  <= '0;
            dcnt <= '0;
            if (half_us == '0) begin
              speed     <= '0;
              zero_flag <= 1'b1;
              state     <= ST_SEND;
            end else begin
              dvd       <= DIV_W'(SPEED_NUM);
              dsr       <= half_us;
              zero_flag <= 1'b0;
              state     <= ST_SPEED;
            end
          end else begin
            dvd  <= dvd_next;
            rem  <= rem_next;
            dcnt <= dcnt + DCNT_W'(1);
          end
        end
        ST_SPEED: begin
          if (div_last) begin
            speed <= dvd_next;
            dcnt  <= '0;
            state <= ST_SEND;
          end else begin
            dvd  <= dvd_next;
            rem  <= rem_next;
            dcnt <= dcnt + DCNT_W'(1);
          end
        end
        ST_SEND: begin
          // Load the result register once it is free or being emptied.
          if (!rslt_valid || !rslt_stall) begin
            rslt.speed         <= speed;
            rslt.elapsed_ms    <= elapsed_total;
            rslt.zero_interval <= zero_flag;
            rslt_valid         <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the prescaler ranging.
  `ACT_ASSERT_SAME(a_prescale_legal, clk, rst, 1'b1,
    (active_prescale == PRESCALE_COARSE || active_prescale == PRESCALE_MID ||
     active_prescale == PRESCALE_FINE),
    "active prescaler left its legal set")
  `ACT_ASSERT_SAME(a_pending_not_coarser, clk, rst, 1'b1,
    (pending_prescale <= active_prescale),
    "pending prescaler is coarser than the active one")
  `ACT_ASSERT_SAME(a_zero_speed, clk, rst, rslt_valid && rslt.zero_interval,
    (rslt.speed == '0), "zero interval reported with nonzero speed")
  `ACT_ASSERT_NEXT(a_stop_clears, clk, rst, req_acc && req.req_type == REQ_STOP,
    (elapsed_total == '0 && active_prescale == PRESCALE_COARSE && stopped),
    "stop did not clear the measurement state")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for autorange_capture_tachometer_core.
// Needs act_pkg and the core; predicts each speed reading and checks it field by field.

module tb;
  import act_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 1890;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rslt_valid;
  logic  rslt_stall;
  rslt_t rslt;

  // Predicted tachometer state.
  prescale_t   tach_active_ps;
  prescale_t   tach_pending_ps;
  logic [31:0] tach_elapsed;
  logic        tach_discard;
  logic        tach_halted;

  rslt_t expected_readings[$];
  rslt_t want;

  int error_count;
  int cycle_count;
  int requests_sent;
  int readings_checked;
  int zero_readings;
  int fine_switches;
  int mid_switches;
  int burst_left;
  bit sender_gaps;

  // Receiver stall pattern and long hold-off control.
  int hold_requests;
  int hold_seen;
  int hold_len;
  int hold_left;
  int stall_mode;
  int stall_mode_left;

  autorange_capture_tachometer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rslt_valid (rslt_valid),
    .rslt_stall (rslt_stall),
    .rslt       (rslt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  // Apply one accepted request to the predicted state and queue any reading.
  function automatic void predict_reading(req_t item);
    prescale_t   used_ps;
    logic [31:0] half_us;
    rslt_t       reading;
    case (item.req_type)
      REQ_START: begin
        tach_halted = 1'b0;
      end
      REQ_STOP: begin
        tach_halted     = 1'b1;
        tach_discard    = 1'b1;
        tach_elapsed    = '0;
        tach_active_ps  = PRESCALE_COARSE;
        tach_pending_ps = PRESCALE_COARSE;
      end
      REQ_CAPTURE: begin
        used_ps        = tach_active_ps;
        tach_active_ps = tach_pending_ps;
        if (tach_discard || tach_halted) begin
          tach_discard = 1'b0;
        end else begin
          half_us      = (32'(item.capture_count) * 32'(used_ps)) / 32'(TPU_SAFE);
          tach_elapsed = tach_elapsed + half_us / 32'(US_PER_MS);
          // Range down: the finest setting wins when the time is short enough.
          if (tach_active_ps > PRESCALE_FINE && half_us < 32'(FINE_LIMIT)) begin
            tach_pending_ps = PRESCALE_FINE;
            fine_switches++;
          end else if (tach_active_ps > PRESCALE_MID && half_us < 32'(MID_LIMIT)) begin
            tach_pending_ps = PRESCALE_MID;
            mid_switches++;
          end
          if (half_us == 0) begin
            reading.speed         = '0;
            reading.zero_interval = 1'b1;
            zero_readings++;
          end else begin
            reading.speed         = 25'(32'(SPEED_NUM) / half_us);
            reading.zero_interval = 1'b0;
          end
          reading.elapsed_ms = tach_elapsed;
          expected_readings.push_back(reading);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one request and hold it until the core takes it; valid stays high while it waits.
  task automatic send_request(logic [1:0] kind, logic [15:0] count);
    req_t item;
    item.req_type      = kind;
    item.capture_count = count;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    predict_reading(item);
    if (kind != REQ_UNUSED) begin
      requests_sent++;
    end
    pace_sender();
  endtask

  // Sender works in bursts separated by idle gaps when gaps are enabled.
  task automatic pace_sender();
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  // Interval counts spread over the ranges that select each prescaler.
  function automatic logic [15:0] random_count();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 20));
      1, 2, 3: return 16'($urandom_range(0, 1000));
      4, 5, 6: return 16'($urandom_range(0, 8000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Edge cases: discards, zero time, extremes and the ranging thresholds.
  task automatic test_directed();
    int mid_edge;
    int fine_edge;
    mid_edge  = (MID_LIMIT * TPU_SAFE + 63) / 64;
    fine_edge = (FINE_LIMIT * TPU_SAFE + 63) / 64;
    sender_gaps = 1'b0;
    // A capture while stopped uses up the discard; unused codes are ignored.
    send_request(REQ_CAPTURE, 16'd100);
    send_request(REQ_UNUSED, 16'hFFFF);
    send_request(REQ_START, 16'h0000);
    send_request(REQ_CAPTURE, 16'hFFFF);
    send_request(REQ_CAPTURE, 16'h0000);
    send_request(REQ_CAPTURE, 16'd1000);
    send_request(REQ_CAPTURE, 16'd15);
    send_request(REQ_CAPTURE, 16'hFFFF);
    send_request(REQ_START, 16'h5A5A);
    // Stop, then the first capture after start is discarded.
    send_request(REQ_STOP, 16'hA5A5);
    send_request(REQ_START, 16'h0000);
    send_request(REQ_CAPTURE, 16'd7);
    send_request(REQ_CAPTURE, 16'd3000);
    send_request(REQ_CAPTURE, 16'd3000);
    send_request(REQ_CAPTURE, 16'd3000);
    send_request(REQ_CAPTURE, 16'd16);
    send_request(REQ_CAPTURE, 16'd16);
    // Coarse prescaler: at and under the mid limit, then under the fine limit.
    send_request(REQ_STOP, 16'h0000);
    send_request(REQ_START, 16'h0000);
    send_request(REQ_CAPTURE, 16'd1);
    send_request(REQ_CAPTURE, 16'(mid_edge));
    send_request(REQ_CAPTURE, 16'(mid_edge - 1));
    send_request(REQ_CAPTURE, 16'(fine_edge - 1));
    send_request(REQ_CAPTURE, 16'(fine_edge));
  endtask

  // The receiver holds off long enough for the core to back up its input.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_len    = 400;
    hold_requests++;
    send_request(REQ_STOP, 16'h0000);
    send_request(REQ_START, 16'h0000);
    repeat (30) send_request(REQ_CAPTURE, random_count());
  endtask

  // Measuring sessions with random content, mixed with stray and broken requests.
  task automatic test_random_sessions(int target);
    int stop_at;
    int n;
    stop_at     = requests_sent + target;
    sender_gaps = 1'b1;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 3))
          0: send_request(REQ_UNUSED, 16'($urandom_range(0, 65535)));
          1: send_request(REQ_CAPTURE, random_count());
          2: send_request(REQ_START, 16'($urandom_range(0, 65535)));
          default: send_request(REQ_STOP, 16'($urandom_range(0, 65535)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        send_request(REQ_STOP, 16'($urandom_range(0, 65535)));
      end
      send_request(REQ_START, 16'($urandom_range(0, 65535)));
      n = $urandom_range(1, 24);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) begin
          send_request($urandom_range(0, 1) ? REQ_START : REQ_UNUSED,
                       16'($urandom_range(0, 65535)));
        end
        send_request(REQ_CAPTURE, random_count());
      end
    end
    req_valid <= 1'b0;
  endtask

  // Receiver: its own stall pattern, overridden by a counted hold-off.
  initial begin
    rslt_stall      <= 1'b0;
    hold_seen       = 0;
    hold_left       = 0;
    stall_mode      = 0;
    stall_mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        rslt_stall <= 1'b1;
      end else begin
        if (stall_mode_left == 0) begin
          stall_mode      = $urandom_range(0, 3);
          stall_mode_left = $urandom_range(20, 200);
        end
        stall_mode_left--;
        case (stall_mode)
          0: rslt_stall <= 1'b0;
          1: rslt_stall <= ($urandom_range(0, 3) == 0);
          2: rslt_stall <= ($urandom_range(0, 3) != 0);
          default: rslt_stall <= ((stall_mode_left % 8) < 5);
        endcase
      end
    end
  end

  // Compare each accepted reading with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rslt_valid && !rslt_stall) begin
      if (expected_readings.size() == 0) begin
        flag_error($sformatf("unexpected reading: speed %0d elapsed %0d zero %0b",
                             rslt.speed, rslt.elapsed_ms, rslt.zero_interval));
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (rslt.speed !== want.speed) begin
          flag_error($sformatf("speed: expected %0d, got %0d", want.speed, rslt.speed));
        end
        if (rslt.elapsed_ms !== want.elapsed_ms) begin
          flag_error($sformatf("elapsed_ms: expected %0d, got %0d",
                               want.elapsed_ms, rslt.elapsed_ms));
        end
        if (rslt.zero_interval !== want.zero_interval) begin
          flag_error($sformatf("zero_interval: expected %0b, got %0b",
                               want.zero_interval, rslt.zero_interval));
        end
      end
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d readings outstanding",
             cycle_count, expected_readings.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Test sequence.
  initial begin
    error_count      = 0;
    requests_sent    = 0;
    readings_checked = 0;
    zero_readings    = 0;
    fine_switches    = 0;
    mid_switches     = 0;
    burst_left       = 0;
    sender_gaps      = 1'b0;
    hold_requests    = 0;
    hold_len         = 0;
    tach_active_ps   = PRESCALE_COARSE;
    tach_pending_ps  = PRESCALE_COARSE;
    tach_elapsed     = '0;
    tach_discard     = 1'b1;
    tach_halted      = 1'b1;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_sessions(RANDOM_ITEMS);

    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      flag_error($sformatf("%0d readings never arrived", expected_readings.size()));
    end

    $display("Sent %0d requests and checked %0d speed readings in %0d cycles.",
             requests_sent, readings_checked, cycle_count);
    $display("Readings with zero time: %0d; switches to prescaler 8: %0d, to 1: %0d.",
             zero_readings, mid_switches, fine_switches);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ autorange_capture_tachometer_core.f @@
+incdir+rtl
rtl/act_pkg.sv
rtl/autorange_capture_tachometer_core.sv
sim/tb.sv
